// ===== rtl/brf_pkg.sv =====
package brf_pkg;

    // Default depth of the shared byte array
    localparam int FILE_DEPTH_DEF = 128;

    // Access codes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Bank select codes
    localparam logic [1:0] BSEL_FOLLOW = 2'd0;
    localparam logic [1:0] BSEL_BANK0  = 2'd1;
    localparam logic [1:0] BSEL_BANK1  = 2'd2;

    // Fixed locations
    localparam logic [7:0] ADDR_INDIRECT = 8'd0;
    localparam logic [7:0] STATUS_LOC    = 8'd3;
    localparam logic [7:0] POINTER_LOC   = 8'd4;
    localparam int         BANK_BIT      = 5;

    // Bank 1 shadow addresses
    localparam logic [7:0] ADDR_OPTION = 8'd1;
    localparam logic [7:0] ADDR_TRIS_A = 8'd5;
    localparam logic [7:0] ADDR_TRIS_B = 8'd6;
    localparam logic [7:0] ADDR_EECON1 = 8'd8;
    localparam logic [7:0] ADDR_EECON2 = 8'd9;

    // Reset values
    localparam logic [7:0] STATUS_RESET = 8'd24;
    localparam logic [7:0] SHADOW_RESET = 8'd255;
    localparam logic [7:0] EECON_RESET  = 8'd0;

    typedef enum logic [2:0] {
        SH_NONE,
        SH_OPTION,
        SH_TRIS_A,
        SH_TRIS_B,
        SH_EECON1,
        SH_EECON2
    } t_shadow;

    // Decoded access target
    typedef struct packed {
        logic [7:0] addr;     // resolved address
        t_shadow    shadow;   // shadow register hit, SH_NONE otherwise
        logic       in_file;  // reaches the shared array
    } t_brf_dec;

endpackage

// ===== rtl/brf_ram.sv =====
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/brf_decode.sv =====
module brf_decode #(
    parameter int FILE_DEPTH = brf_pkg::FILE_DEPTH_DEF
) (
    input  logic [7:0]        i_address,
    input  logic [1:0]        i_bank_select,
    input  logic [7:0]        i_status,
    input  logic [7:0]        i_pointer,
    output brf_pkg::t_brf_dec o_dec
);

    import brf_pkg::*;

    logic       bank1;
    logic [7:0] addr;
    t_shadow    shadow;

    // Indirection resolves once; a zero pointer lands on location 0
    assign addr = (i_address == ADDR_INDIRECT) ? i_pointer : i_address;

    always_comb begin
        unique case (i_bank_select)
            BSEL_BANK0: bank1 = 1'b0;
            BSEL_BANK1: bank1 = 1'b1;
            default:    bank1 = i_status[BANK_BIT];
        endcase
    end

    always_comb begin
        shadow = SH_NONE;
        if (bank1) begin
            unique case (addr)
                ADDR_OPTION: shadow = SH_OPTION;
                ADDR_TRIS_A: shadow = SH_TRIS_A;
                ADDR_TRIS_B: shadow = SH_TRIS_B;
                ADDR_EECON1: shadow = SH_EECON1;
                ADDR_EECON2: shadow = SH_EECON2;
                default:     shadow = SH_NONE;
            endcase
        end
    end

    assign o_dec.addr    = addr;
    assign o_dec.shadow  = shadow;
    assign o_dec.in_file = (shadow == SH_NONE) && ({1'b0, addr} < 9'(FILE_DEPTH));

endmodule

// ===== rtl/banked_register_file.sv =====
// Banked data register file: one read or write access per transaction.
// Input channel: i_in_valid / o_in_stall with i_operation, i_address,
// i_write_data, i_bank_select. A transaction is taken on a rising edge with
// valid high and stall low.
// Output channel: o_out_valid / i_out_stall with o_read_data, o_out_of_range,
// one result per input transaction, in order.
// Each result passes through the array read stage and then the result register.
// Throughput: one access per cycle while o_in_stall is low; the address decode, shadow registers and
// the single-port array (registered read) each handle one access a cycle.
// Writes commit at the accepting edge, so the next access sees them.
// Reset (synchronous, i_rst_n low): shared array reads as zero except status
// (location 3 = 24), option and tristate shadows = 255, EEPROM controls = 0.
// No clearing pass is needed: per-entry written flags mask stale array data.
// Stalls: with i_out_stall high the result register holds; one more result
// sits in the array read stage, after which o_in_stall rises.
module banked_register_file #(
    parameter int FILE_DEPTH = brf_pkg::FILE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_operation,
    input  logic [7:0] i_address,
    input  logic [7:0] i_write_data,
    input  logic [1:0] i_bank_select,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_read_data,
    output logic       o_out_of_range
);

    import brf_pkg::*;

    localparam int AW = $clog2(FILE_DEPTH);

    // Locations 3 and 4 are mirrored in registers: decode needs them every cycle
    logic [7:0] r_status, n_status;
    logic [7:0] r_pointer, n_pointer;

    // Bank 1 shadow registers
    logic [7:0] r_option, n_option;
    logic [7:0] r_tris_a, n_tris_a;
    logic [7:0] r_tris_b, n_tris_b;
    logic [7:0] r_eecon1, n_eecon1;
    logic [7:0] r_eecon2, n_eecon2;

    // One flag per array entry; unwritten entries read as zero
    logic [FILE_DEPTH-1:0] r_written, n_written;

    // Array read stage
    logic       r_s1_vld, n_s1_vld;
    logic       r_s1_use_ram, n_s1_use_ram;
    logic [7:0] r_s1_byte, n_s1_byte;
    logic       r_s1_oor, n_s1_oor;

    // Result register
    logic       r_out_vld, n_out_vld;
    logic [7:0] r_out_data, n_out_data;
    logic       r_out_oor, n_out_oor;

    t_brf_dec   dec;
    logic       acc;
    logic       is_wr;
    logic       out_free;
    logic       s1_move;
    logic       ram_en;
    logic [7:0] ram_rdata;
    logic       hit_status;
    logic       hit_pointer;
    logic       entry_written;

    brf_decode #(
        .FILE_DEPTH(FILE_DEPTH)
    ) u_decode (
        .i_address    (i_address),
        .i_bank_select(i_bank_select),
        .i_status     (r_status),
        .i_pointer    (r_pointer),
        .o_dec        (dec)
    );

    brf_ram #(
        .WIDTH(8),
        .DEPTH(FILE_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_en   (ram_en),
        .i_we   (is_wr),
        .i_addr (dec.addr[AW-1:0]),
        .i_wdata(i_write_data),
        .o_rdata(ram_rdata)
    );

    // Handshake: the read stage drains whenever the result register is free
    assign out_free   = !r_out_vld || !i_out_stall;
    assign s1_move    = r_s1_vld && out_free;
    assign o_in_stall = r_s1_vld && !out_free;
    assign acc        = i_in_valid && !o_in_stall;
    assign is_wr      = (i_operation == OP_WRITE);
    assign ram_en     = acc && dec.in_file;

    assign hit_status    = dec.in_file && (dec.addr == STATUS_LOC);
    assign hit_pointer   = dec.in_file && (dec.addr == POINTER_LOC);
    assign entry_written = r_written[dec.addr[AW-1:0]];

    // Register updates on write transactions
    always_comb begin
        n_status  = r_status;
        n_pointer = r_pointer;
        n_option  = r_option;
        n_tris_a  = r_tris_a;
        n_tris_b  = r_tris_b;
        n_eecon1  = r_eecon1;
        n_eecon2  = r_eecon2;
        n_written = r_written;
        if (acc && is_wr) begin
            unique case (dec.shadow)
                SH_OPTION: n_option = i_write_data;
                SH_TRIS_A: n_tris_a = i_write_data;
                SH_TRIS_B: n_tris_b = i_write_data;
                SH_EECON1: n_eecon1 = i_write_data;
                SH_EECON2: n_eecon2 = i_write_data;
                default: begin
                    // out-of-range writes fall through with no effect
                    if (dec.in_file) begin
                        n_written[dec.addr[AW-1:0]] = 1'b1;
                    end
                    if (hit_status) begin
                        n_status = i_write_data;
                    end
                    if (hit_pointer) begin
                        n_pointer = i_write_data;
                    end
                end
            endcase
        end
    end

    // Read stage capture: register-held bytes are taken now, array data is taken
    // from the RAM's read register, which is loaded alongside this stage
    always_comb begin
        n_s1_vld     = acc || (r_s1_vld && !s1_move);
        n_s1_use_ram = r_s1_use_ram;
        n_s1_byte    = r_s1_byte;
        n_s1_oor     = r_s1_oor;
        if (acc) begin
            n_s1_oor     = (dec.shadow == SH_NONE) && !dec.in_file;
            n_s1_use_ram = 1'b0;
            n_s1_byte    = 8'd0;
            if (!is_wr) begin
                unique case (dec.shadow)
                    SH_OPTION: n_s1_byte = r_option;
                    SH_TRIS_A: n_s1_byte = r_tris_a;
                    SH_TRIS_B: n_s1_byte = r_tris_b;
                    SH_EECON1: n_s1_byte = r_eecon1;
                    SH_EECON2: n_s1_byte = r_eecon2;
                    default: begin
                        if (hit_status) begin
                            n_s1_byte = r_status;
                        end else if (hit_pointer) begin
                            n_s1_byte = r_pointer;
                        end else begin
                            n_s1_use_ram = dec.in_file && entry_written;
                        end
                    end
                endcase
            end
        end
    end

    // Result register
    always_comb begin
        n_out_vld  = s1_move || (r_out_vld && i_out_stall);
        n_out_data = r_out_data;
        n_out_oor  = r_out_oor;
        if (s1_move) begin
            n_out_data = r_s1_use_ram ? ram_rdata : r_s1_byte;
            n_out_oor  = r_s1_oor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status  <= STATUS_RESET;
            r_pointer <= 8'd0;
            r_option  <= SHADOW_RESET;
            r_tris_a  <= SHADOW_RESET;
            r_tris_b  <= SHADOW_RESET;
            r_eecon1  <= EECON_RESET;
            r_eecon2  <= EECON_RESET;
            r_written <= '0;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_status  <= n_status;
            r_pointer <= n_pointer;
            r_option  <= n_option;
            r_tris_a  <= n_tris_a;
            r_tris_b  <= n_tris_b;
            r_eecon1  <= n_eecon1;
            r_eecon2  <= n_eecon2;
            r_written <= n_written;
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_s1_use_ram <= n_s1_use_ram;
        r_s1_byte    <= n_s1_byte;
        r_s1_oor     <= n_s1_oor;
        r_out_data   <= n_out_data;
        r_out_oor    <= n_out_oor;
    end

    assign o_out_valid    = r_out_vld;
    assign o_read_data    = r_out_data;
    assign o_out_of_range = r_out_oor;

endmodule
